[src/ppp_pkg.sv]
// Package for the position message parser: queue entry type and wire-format constants.
// No dependencies; imported by the front, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

    // One queued payload byte, already classified by the front part
    typedef struct packed {
        logic [7:0] data;   // raw byte
        logic       cont;   // varint continuation bit (bit 7)
        logic       last;   // final byte of the payload
    } t_q_item;

    // Wire types of the protobuf wire format
    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_LENGTH  = 3'd2;
    localparam logic [2:0] WIRE_FIXED32 = 3'd5;

    // Field numbers kept from fixed32 values
    localparam logic [28:0] FIELD_LAT  = 29'd1;
    localparam logic [28:0] FIELD_LON  = 29'd2;
    localparam logic [28:0] FIELD_TIME = 29'd4;

    // Varint and fixed-width stepping
    localparam logic [5:0]  VARINT_STEP = 6'd7;
    localparam logic [5:0]  FIXED_STEP  = 6'd8;
    localparam logic [5:0]  SHIFT_LIMIT = 6'd32;
    localparam logic [31:0] FIXED32_LEN = 32'd4;
    localparam logic [31:0] FIXED64_LEN = 32'd8;

endpackage

`default_nettype wire

[src/ppp_byte_if.sv]
// Byte channel into the position parser: valid/ready handshake with one payload byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ppp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[src/ppp_res_if.sv]
// Result channel out of the position parser: valid/ready handshake with the decoded position.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ppp_res_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic        [31:0] fix_time;

    modport source (output valid, output ok, output latitude, output longitude,
                    output fix_time, input ready);
    modport sink   (input valid, input ok, input latitude, input longitude,
                    input fix_time, output ready);
endinterface

`default_nettype wire

[src/ppp_front.sv]
// Front part of the position parser: accepts bytes, classifies them and queues them.
// Depends on ppp_pkg and ppp_byte_if.
`timescale 1ns / 1ps
`default_nettype none

module ppp_front
    import ppp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ppp_byte_if.sink  i_in,
    output t_q_item   o_q_item,
    output logic      o_q_valid,
    input  wire logic i_pop
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    t_q_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               push;
    t_q_item            in_item;

    // Classify the incoming byte
    always_comb begin
        in_item.data = i_in.data_byte;
        in_item.cont = i_in.data_byte[7];
        in_item.last = i_in.last_byte;
    end

    assign i_in.ready = (r_count != COUNT_W'(QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the transfer in the queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_q_valid)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

[src/ppp_back.sv]
// Back part of the position parser, depends on ppp_pkg and ppp_res_if: walks the wire
// format one queued byte per cycle (a last byte waits for the result slot) and registers the result.
`timescale 1ns / 1ps
`default_nettype none

module ppp_back
    import ppp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_q_item i_q_item,
    input  wire logic i_q_valid,
    output logic      o_pop,
    ppp_res_if.source o_out
);

    typedef enum logic [2:0] {
        PH_TAG  = 3'd0,
        PH_VAL  = 3'd1,
        PH_LEN  = 3'd2,
        PH_FIX  = 3'd3,
        PH_SKIP = 3'd4,
        PH_ERR  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_LAT  = 2'd1,
        TGT_LON  = 2'd2,
        TGT_TIME = 2'd3
    } t_target;

    t_phase      r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic [5:0]  r_shift, n_shift;
    t_target     r_target, n_target;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_lat, n_lat;
    logic [31:0] r_lon, n_lon;
    logic [31:0] r_time, n_time;
    logic        r_seen_lat, n_seen_lat;
    logic        r_seen_lon, n_seen_lon;
    logic        r_err, n_err;

    logic        r_out_valid;
    logic        r_ok;
    logic [31:0] r_out_lat, r_out_lon, r_out_time;

    logic        out_free;
    logic        finish;
    logic        in_range;
    logic [31:0] v_acc, f_acc;
    logic [5:0]  v_shift;
    logic [31:0] dec_cnt;
    logic        end_err;
    logic        res_ok;

    // Pop when the byte can be consumed; a last byte also needs the result slot
    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = i_q_valid && (!i_q_item.last || out_free);
    assign finish   = o_pop && i_q_item.last;

    // Varint and fixed32 accumulation terms
    assign in_range = (r_shift < SHIFT_LIMIT);
    assign v_acc    = in_range ? (r_acc | ({25'd0, i_q_item.data[6:0]} << r_shift[4:0]))
                               : r_acc;
    assign v_shift  = in_range ? r_shift + VARINT_STEP : r_shift;
    assign f_acc    = in_range ? (r_acc | ({24'd0, i_q_item.data} << r_shift[4:0]))
                               : r_acc;
    assign dec_cnt  = r_cnt - 32'd1;

    // Decode one byte
    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_shift    = r_shift;
        n_target   = r_target;
        n_cnt      = r_cnt;
        n_lat      = r_lat;
        n_lon      = r_lon;
        n_time     = r_time;
        n_seen_lat = r_seen_lat;
        n_seen_lon = r_seen_lon;
        n_err      = r_err;
        if (o_pop) begin
            unique case (r_phase)
                PH_TAG: begin
                    n_acc   = v_acc;
                    n_shift = v_shift;
                    if (!i_q_item.cont) begin
                        n_target = TGT_NONE;
                        n_acc    = '0;
                        n_shift  = '0;
                        unique case (v_acc[2:0])
                            WIRE_VARINT: n_phase = PH_VAL;
                            WIRE_LENGTH: n_phase = PH_LEN;
                            WIRE_FIXED32: begin
                                n_phase = PH_FIX;
                                n_cnt   = FIXED32_LEN;
                                priority if (v_acc[31:3] == FIELD_LAT) begin
                                    n_target = TGT_LAT;
                                end else if (v_acc[31:3] == FIELD_LON) begin
                                    n_target = TGT_LON;
                                end else if (v_acc[31:3] == FIELD_TIME) begin
                                    n_target = TGT_TIME;
                                end else begin
                                    n_target = TGT_NONE;
                                end
                            end
                            WIRE_FIXED64: begin
                                n_phase = PH_SKIP;
                                n_cnt   = FIXED64_LEN;
                            end
                            default: begin
                                // Unsupported wire type: drain until the last byte
                                n_acc   = v_acc;
                                n_shift = v_shift;
                                n_err   = 1'b1;
                                n_phase = PH_ERR;
                            end
                        endcase
                    end
                end
                PH_VAL: begin
                    n_acc   = v_acc;
                    n_shift = v_shift;
                    if (!i_q_item.cont) begin
                        n_phase = PH_TAG;
                        n_acc   = '0;
                        n_shift = '0;
                    end
                end
                PH_LEN: begin
                    n_acc   = v_acc;
                    n_shift = v_shift;
                    if (!i_q_item.cont) begin
                        n_acc   = '0;
                        n_shift = '0;
                        if (v_acc == '0) begin
                            n_phase = PH_TAG;
                        end else begin
                            n_phase = PH_SKIP;
                            n_cnt   = v_acc;
                        end
                    end
                end
                PH_FIX: begin
                    n_acc   = f_acc;
                    n_shift = r_shift + FIXED_STEP;
                    n_cnt   = dec_cnt;
                    if (dec_cnt == '0) begin
                        unique case (r_target)
                            TGT_LAT: begin
                                n_lat      = f_acc;
                                n_seen_lat = 1'b1;
                            end
                            TGT_LON: begin
                                n_lon      = f_acc;
                                n_seen_lon = 1'b1;
                            end
                            TGT_TIME: n_time = f_acc;
                            TGT_NONE: ;
                        endcase
                        n_target = TGT_NONE;
                        n_phase  = PH_TAG;
                        n_acc    = '0;
                        n_shift  = '0;
                    end
                end
                PH_SKIP: begin
                    n_cnt = dec_cnt;
                    if (dec_cnt == '0) begin
                        n_phase = PH_TAG;
                        n_acc   = '0;
                        n_shift = '0;
                    end
                end
                PH_ERR: ;
                default: ;
            endcase
        end
    end

    // Judge the end of the payload in the phase reached
    always_comb begin
        unique case (n_phase)
            PH_TAG:  end_err = (n_shift != '0) &&
                               !((n_acc[2:0] == WIRE_VARINT) || (n_acc[2:0] == WIRE_LENGTH));
            PH_VAL:  end_err = 1'b0;
            PH_LEN:  end_err = (n_acc != '0);
            default: end_err = 1'b1;
        endcase
        res_ok = !(n_err || end_err) && n_seen_lat && n_seen_lon;
    end

    // Hold decoder state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_phase    <= PH_TAG;
            r_acc      <= '0;
            r_shift    <= '0;
            r_target   <= TGT_NONE;
            r_cnt      <= '0;
            r_lat      <= '0;
            r_lon      <= '0;
            r_time     <= '0;
            r_seen_lat <= 1'b0;
            r_seen_lon <= 1'b0;
            r_err      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_shift    <= n_shift;
            r_target   <= n_target;
            r_cnt      <= n_cnt;
            r_lat      <= n_lat;
            r_lon      <= n_lon;
            r_time     <= n_time;
            r_seen_lat <= n_seen_lat;
            r_seen_lon <= n_seen_lon;
            r_err      <= n_err;
        end
    end

    // Result register: load on the last byte, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_ok       <= res_ok;
            r_out_lat  <= res_ok ? n_lat  : '0;
            r_out_lon  <= res_ok ? n_lon  : '0;
            r_out_time <= res_ok ? n_time : '0;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.ok        = r_ok;
    assign o_out.latitude  = signed'(r_out_lat);
    assign o_out.longitude = signed'(r_out_lon);
    assign o_out.fix_time  = r_out_time;

    a_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERR) |-> r_err)
        else $error("drain phase without error flag");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_phase == PH_TAG) && (r_shift == '0) && !r_err &&
                   !r_seen_lat && !r_seen_lon)
        else $error("decoder not cleared after last byte");

    a_bad_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ok) |-> (r_out_lat == '0) && (r_out_lon == '0) &&
                                   (r_out_time == '0))
        else $error("failed result carries a position");

    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !finish)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[src/protobuf_position_parser.sv]
// Position message parser for the protobuf wire format, one byte per cycle.
// Channels: i_in carries payload bytes (data_byte, last_byte) under valid/ready;
// o_out carries one result per payload (ok, latitude, longitude, fix_time).
// Fixed32 fields 1, 2 and 4 give latitude, longitude and time, the last one wins.
// ok is set when the payload is well formed and both latitude and longitude were
// present; otherwise all three values read as zero.
// Throughput: one byte per cycle, set by the decoder's single-byte step, until a stall holds a last byte.
// The last byte passes through the byte queue (where it waits while an earlier
// result is still held), then loads the result register, which drives o_out.
// Reset (i_rst_n low at a clock edge) empties the queue, clears the decoder and
// drops any pending result.
// When the receiver stalls, the result register holds its value; bytes of the
// next payload keep flowing until its last byte, which waits in the queue until
// the result is taken. i_in.ready drops only when the queue is full.
// Depends on ppp_pkg, ppp_byte_if, ppp_res_if, ppp_front and ppp_back.
`timescale 1ns / 1ps
`default_nettype none

module protobuf_position_parser
    import ppp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ppp_byte_if.sink  i_in,
    ppp_res_if.source o_out
);

    t_q_item q_item;
    logic    q_valid;
    logic    q_pop;

    // Accept and queue bytes
    ppp_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_item  (q_item),
        .o_q_valid (q_valid),
        .i_pop     (q_pop)
    );

    // Decode and deliver results
    ppp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (q_item),
        .i_q_valid (q_valid),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

[dv/tb_protobuf_position_parser.sv]
// Testbench for protobuf_position_parser: directed and random payloads, with an in-bench decoder.
// Depends on ppp_pkg, ppp_byte_if, ppp_res_if and the parser RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_protobuf_position_parser;
    import ppp_pkg::*;

    // Wire types that the decoder must reject
    localparam logic [2:0] WIRE_SGROUP = 3'd3;
    localparam logic [2:0] WIRE_EGROUP = 3'd4;
    localparam logic [2:0] WIRE_RSVD6  = 3'd6;
    localparam logic [2:0] WIRE_RSVD7  = 3'd7;

    localparam int MAX_PRINTED = 40;

    typedef enum logic [2:0] {
        DEC_TAG, DEC_VALUE, DEC_LENGTH, DEC_FIXED, DEC_SKIP, DEC_DRAIN
    } t_dec_phase;

    typedef enum logic [1:0] {KEEP_NONE, KEEP_LAT, KEEP_LON, KEEP_TIME} t_keep;

    typedef struct packed {
        logic        ok;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] fix_time;
    } t_position;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ppp_byte_if byte_if ();
    ppp_res_if  res_if ();

    protobuf_position_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Decoder state mirrored from the block
    t_dec_phase  dec_phase;
    logic [31:0] dec_acc;
    logic [5:0]  dec_shift;
    t_keep       dec_keep;
    logic [31:0] dec_count;
    logic [31:0] dec_lat;
    logic [31:0] dec_lon;
    logic [31:0] dec_time;
    logic        dec_seen_lat;
    logic        dec_seen_lon;
    logic        dec_err;

    t_position   expected_fixes[$];
    t_position   next_fix;
    logic [7:0]  msg_bytes[$];

    int mismatch_count = 0;
    int payload_count  = 0;
    int bytes_sent     = 0;
    int tx_gap_max     = 0;
    int rx_stall_max   = 0;
    int burst_left     = 0;
    int rx_left        = 0;

    // ------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------

    function automatic void enter_phase(t_dec_phase next);
        dec_phase = next;
        dec_acc   = '0;
        dec_shift = '0;
    endfunction

    function automatic void clear_decoder();
        enter_phase(DEC_TAG);
        dec_keep     = KEEP_NONE;
        dec_count    = '0;
        dec_lat      = '0;
        dec_lon      = '0;
        dec_time     = '0;
        dec_seen_lat = 1'b0;
        dec_seen_lon = 1'b0;
        dec_err      = 1'b0;
    endfunction

    // Add one varint group; bits above weight 2^31 fall off the top
    function automatic logic varint_done(logic [7:0] b);
        if (dec_shift < SHIFT_LIMIT) begin
            dec_acc   = dec_acc | (32'(b[6:0]) << dec_shift);
            dec_shift = dec_shift + VARINT_STEP;
        end
        return !b[7];
    endfunction

    function automatic void finish_tag();
        logic [28:0] fld;
        logic [2:0]  wtype;
        fld      = dec_acc[31:3];
        wtype    = dec_acc[2:0];
        dec_keep = KEEP_NONE;
        if (wtype == WIRE_VARINT) begin
            enter_phase(DEC_VALUE);
        end else if (wtype == WIRE_LENGTH) begin
            enter_phase(DEC_LENGTH);
        end else if (wtype == WIRE_FIXED32) begin
            if (fld == FIELD_LAT)       dec_keep = KEEP_LAT;
            else if (fld == FIELD_LON)  dec_keep = KEEP_LON;
            else if (fld == FIELD_TIME) dec_keep = KEEP_TIME;
            enter_phase(DEC_FIXED);
            dec_count = FIXED32_LEN;
        end else if (wtype == WIRE_FIXED64) begin
            enter_phase(DEC_SKIP);
            dec_count = FIXED64_LEN;
        end else begin
            dec_err   = 1'b1;
            dec_phase = DEC_DRAIN;
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        case (dec_phase)
            DEC_TAG: begin
                if (varint_done(b)) finish_tag();
            end
            DEC_VALUE: begin
                if (varint_done(b)) enter_phase(DEC_TAG);
            end
            DEC_LENGTH: begin
                if (varint_done(b)) begin
                    if (dec_acc == '0) begin
                        enter_phase(DEC_TAG);
                    end else begin
                        dec_count = dec_acc;
                        enter_phase(DEC_SKIP);
                    end
                end
            end
            DEC_FIXED: begin
                if (dec_shift < SHIFT_LIMIT) dec_acc = dec_acc | (32'(b) << dec_shift);
                dec_shift = dec_shift + FIXED_STEP;
                dec_count = dec_count - 1;
                if (dec_count == '0) begin
                    case (dec_keep)
                        KEEP_LAT: begin
                            dec_lat      = dec_acc;
                            dec_seen_lat = 1'b1;
                        end
                        KEEP_LON: begin
                            dec_lon      = dec_acc;
                            dec_seen_lon = 1'b1;
                        end
                        KEEP_TIME: dec_time = dec_acc;
                        default: ;
                    endcase
                    dec_keep = KEEP_NONE;
                    enter_phase(DEC_TAG);
                end
            end
            DEC_SKIP: begin
                dec_count = dec_count - 1;
                if (dec_count == '0) enter_phase(DEC_TAG);
            end
            default: ;
        endcase
    endfunction

    // Judge a payload that stops in the current phase
    function automatic logic ends_badly();
        case (dec_phase)
            DEC_TAG:    return (dec_shift != '0) &&
                               !(dec_acc[2:0] == WIRE_VARINT || dec_acc[2:0] == WIRE_LENGTH);
            DEC_VALUE:  return 1'b0;
            DEC_LENGTH: return dec_acc != '0;
            default:    return 1'b1;
        endcase
    endfunction

    function automatic void predict_transfer(logic [7:0] b, logic is_last);
        t_position fix;
        if (dec_phase != DEC_DRAIN) decode_byte(b);
        if (is_last) begin
            if (ends_badly()) dec_err = 1'b1;
            fix.ok       = !dec_err && dec_seen_lat && dec_seen_lon;
            fix.lat      = fix.ok ? dec_lat  : '0;
            fix.lon      = fix.ok ? dec_lon  : '0;
            fix.fix_time = fix.ok ? dec_time : '0;
            expected_fixes.push_back(fix);
            clear_decoder();
        end
    endfunction

    // Predict on every byte transfer
    always @(posedge i_clk) begin
        if (i_rst_n && byte_if.valid && byte_if.ready)
            predict_transfer(byte_if.data_byte, byte_if.last_byte);
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("ERROR @%0t payload result: %s expected %h got %h", $time, what, want, got);
    endtask

    // Compare each result transfer with the oldest expected fix
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_fixes.size() == 0) begin
                report_mismatch("result with none pending, ok", 32'd0, 32'(res_if.ok));
            end else begin
                next_fix = expected_fixes.pop_front();
                if (res_if.ok !== next_fix.ok)
                    report_mismatch("ok", 32'(next_fix.ok), 32'(res_if.ok));
                if (res_if.latitude !== next_fix.lat)
                    report_mismatch("latitude", next_fix.lat, res_if.latitude);
                if (res_if.longitude !== next_fix.lon)
                    report_mismatch("longitude", next_fix.lon, res_if.longitude);
                if (res_if.fix_time !== next_fix.fix_time)
                    report_mismatch("fix_time", next_fix.fix_time, res_if.fix_time);
            end
        end
    end

    // Receiver: runs of ready broken by random stalls; rx_stall_max of zero gives no stalls
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_left != 0) begin
                rx_left--;
            end else if (res_if.ready && rx_stall_max != 0) begin
                res_if.ready <= 1'b0;
                rx_left = $urandom_range(rx_stall_max, 1);
            end else begin
                res_if.ready <= 1'b1;
                rx_left = $urandom_range(12, 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sending
    // ------------------------------------------------------------------

    // Send one byte; open a new burst with a random gap when the last one ran out
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(16, 1);
            gap = (tx_gap_max != 0) ? $urandom_range(tx_gap_max, 0) : 0;
            if (gap != 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.last_byte <= is_last;
        do @(posedge i_clk); while (!byte_if.ready);
        bytes_sent++;
    endtask

    task automatic send_msg();
        if (msg_bytes.size() == 0) msg_bytes.push_back(8'($urandom));
        foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
        payload_count++;
    endtask

    // Hold the sender until every expected fix has come out
    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_fixes.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Payload building
    // ------------------------------------------------------------------

    // Varint of v, padded with pad further zero groups
    function automatic void put_varint(logic [31:0] v, int pad);
        logic [31:0] rest;
        rest = v;
        while (rest >= 32'h80) begin
            msg_bytes.push_back({1'b1, rest[6:0]});
            rest = rest >> 7;
        end
        if (pad == 0) begin
            msg_bytes.push_back({1'b0, rest[6:0]});
        end else begin
            msg_bytes.push_back({1'b1, rest[6:0]});
            repeat (pad - 1) msg_bytes.push_back(8'h80);
            msg_bytes.push_back(8'h00);
        end
    endfunction

    // Varint with more than 32 bits of weight: ones in the low groups, random top
    function automatic void put_wide_varint(int extra);
        repeat (4 + extra) msg_bytes.push_back(8'hff);
        msg_bytes.push_back({1'b0, 7'($urandom)});
    endfunction

    function automatic void put_tag(logic [28:0] fld, logic [2:0] wtype);
        put_varint({fld, wtype}, 0);
    endfunction

    function automatic void put_fixed32(logic [31:0] v);
        for (int i = 0; i < 4; i++) msg_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_position(logic [31:0] lat, logic [31:0] lon);
        put_tag(FIELD_LAT, WIRE_FIXED32);
        put_fixed32(lat);
        put_tag(FIELD_LON, WIRE_FIXED32);
        put_fixed32(lon);
    endfunction

    function automatic logic [28:0] pick_field();
        return ($urandom_range(3, 0) == 0) ? 29'($urandom) : 29'($urandom_range(20, 0));
    endfunction

    // One random field of any kind the decoder accepts
    function automatic void put_random_field();
        logic [28:0] fld;
        int len;
        case ($urandom_range(9, 0))
            0, 1: begin
                put_tag(FIELD_LAT, WIRE_FIXED32);
                put_fixed32($urandom);
            end
            2, 3: begin
                put_tag(FIELD_LON, WIRE_FIXED32);
                put_fixed32($urandom);
            end
            4: begin
                put_tag(FIELD_TIME, WIRE_FIXED32);
                put_fixed32($urandom);
            end
            5: begin
                do fld = pick_field();
                while (fld == FIELD_LAT || fld == FIELD_LON || fld == FIELD_TIME);
                put_tag(fld, WIRE_FIXED32);
                put_fixed32($urandom);
            end
            6: begin
                put_tag(pick_field(), WIRE_VARINT);
                if ($urandom_range(5, 0) == 0) put_wide_varint($urandom_range(4, 0));
                else put_varint($urandom >> $urandom_range(31, 0),
                                ($urandom_range(7, 0) == 0) ? $urandom_range(4, 1) : 0);
            end
            7: begin
                len = $urandom_range(6, 0);
                put_tag(pick_field(), WIRE_LENGTH);
                put_varint(len, ($urandom_range(7, 0) == 0) ? 1 : 0);
                repeat (len) msg_bytes.push_back(8'($urandom));
            end
            8: begin
                put_tag(pick_field(), WIRE_FIXED64);
                put_fixed32($urandom);
                put_fixed32($urandom);
            end
            default: begin
                // kept field under an overlong tag
                put_varint({29'($urandom_range(2, 1)), WIRE_FIXED32}, $urandom_range(3, 1));
                put_fixed32($urandom);
            end
        endcase
    endfunction

    function automatic logic [2:0] pick_bad_wire();
        case ($urandom_range(3, 0))
            0:       return WIRE_SGROUP;
            1:       return WIRE_EGROUP;
            2:       return WIRE_RSVD6;
            default: return WIRE_RSVD7;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_basic_fixes();
        // coordinate and time extremes
        put_position(32'h8000_0000, 32'h7fff_ffff);
        put_tag(FIELD_TIME, WIRE_FIXED32);
        put_fixed32(32'hffff_ffff);
        send_msg();
        put_position(32'h7fff_ffff, 32'h8000_0000);
        send_msg();
        put_position(32'h0000_0000, 32'hffff_ffff);
        send_msg();
        // latitude alone does not make a fix
        put_tag(FIELD_LAT, WIRE_FIXED32);
        put_fixed32(32'h1234_5678);
        send_msg();
    endtask

    task automatic test_repeated_fields();
        put_position(32'h0101_0101, 32'h0202_0202);
        put_tag(FIELD_TIME, WIRE_FIXED32);
        put_fixed32(32'h0303_0303);
        put_tag(FIELD_LAT, WIRE_FIXED32);
        put_fixed32(32'hfeed_beef);
        put_tag(FIELD_TIME, WIRE_FIXED32);
        put_fixed32(32'h5a5a_a5a5);
        put_tag(29'd3, WIRE_FIXED32);
        put_fixed32(32'hdead_dead);
        put_tag(FIELD_LON, WIRE_FIXED32);
        put_fixed32(32'hc0de_0001);
        send_msg();
    endtask

    task automatic test_skipped_wire_types();
        put_tag(29'd5, WIRE_VARINT);
        put_varint(32'd300, 0);
        put_tag(29'd7, WIRE_LENGTH);
        put_varint(32'd3, 0);
        put_fixed32(32'h00_ffaa55);
        msg_bytes.pop_back();
        // zero length: next byte is a tag
        put_tag(29'd8, WIRE_LENGTH);
        put_varint(32'd0, 0);
        put_tag(29'd9, WIRE_FIXED64);
        put_fixed32(32'hffff_ffff);
        put_fixed32(32'hffff_ffff);
        put_varint({FIELD_LAT, WIRE_FIXED32}, 2);
        put_fixed32(32'h0abc_def0);
        put_tag(FIELD_LON, WIRE_FIXED32);
        put_fixed32(32'h8765_4321);
        send_msg();
    endtask

    // Any other wire type fails the payload; later fields are ignored
    task automatic test_bad_wire_types();
        logic [2:0] bad_wires[4];
        bad_wires = '{WIRE_SGROUP, WIRE_EGROUP, WIRE_RSVD6, WIRE_RSVD7};
        foreach (bad_wires[i]) begin
            put_position($urandom, $urandom);
            put_tag(29'(i + 1), bad_wires[i]);
            put_position($urandom, $urandom);
            send_msg();
        end
    endtask

    task automatic test_payload_endings();
        // inside a value varint: fine
        put_position(32'h1111_2222, 32'h3333_4444);
        put_tag(29'd6, WIRE_VARINT);
        msg_bytes.push_back(8'hff);
        send_msg();
        // inside a tag: judged by its wire type so far
        put_position(32'h1, 32'h2);
        msg_bytes.push_back({1'b1, 4'd0, WIRE_VARINT});
        send_msg();
        put_position(32'h3, 32'h4);
        msg_bytes.push_back({1'b1, 4'd1, WIRE_FIXED32});
        send_msg();
        // right after a tag of each wire type
        put_position(32'h5, 32'h6);
        put_tag(29'd9, WIRE_VARINT);
        send_msg();
        put_position(32'h7, 32'h8);
        put_tag(29'd9, WIRE_LENGTH);
        send_msg();
        put_position(32'h9, 32'ha);
        put_tag(29'd9, WIRE_FIXED32);
        send_msg();
        put_position(32'hb, 32'hc);
        put_tag(29'd9, WIRE_FIXED64);
        send_msg();
        // inside a length varint: non-zero part fails, zero part does not
        put_position(32'hd, 32'he);
        put_tag(29'd9, WIRE_LENGTH);
        msg_bytes.push_back(8'h83);
        send_msg();
        put_position(32'hf, 32'h10);
        put_tag(29'd9, WIRE_LENGTH);
        msg_bytes.push_back(8'h80);
        send_msg();
        // inside a fixed32 and inside a skipped payload
        put_position(32'h11, 32'h12);
        put_tag(FIELD_LAT, WIRE_FIXED32);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'h00);
        send_msg();
        put_position(32'h13, 32'h14);
        put_tag(29'd9, WIRE_LENGTH);
        put_varint(32'd4, 0);
        msg_bytes.push_back(8'h77);
        send_msg();
        // one-byte payloads
        msg_bytes.push_back(8'h00);
        send_msg();
        msg_bytes.push_back(8'hff);
        send_msg();
    endtask

    task automatic test_long_varints();
        // value bits past 32 dropped, fix still good
        put_tag(29'd12, WIRE_VARINT);
        put_wide_varint(5);
        put_position(32'h4242_4242, 32'hbdbd_bdbd);
        send_msg();
        // huge length truncated to 32 bits, payload ends inside the skip
        put_position(32'h1, 32'h1);
        put_tag(29'd13, WIRE_LENGTH);
        put_wide_varint(1);
        repeat (3) msg_bytes.push_back(8'($urandom));
        send_msg();
        // wide tag: wire type from the low bits
        put_wide_varint(2);
        put_position(32'h2, 32'h2);
        send_msg();
    endtask

    task automatic test_random_traffic();
        int kind;
        int keep;
        while (bytes_sent < 700) begin
            // switch idle profile now and then, including no idling at all
            if (payload_count % 12 == 0) begin
                case ($urandom_range(3, 0))
                    0: begin tx_gap_max = 0; rx_stall_max = 0;  end
                    1: begin tx_gap_max = 4; rx_stall_max = 0;  end
                    2: begin tx_gap_max = 0; rx_stall_max = 12; end
                    default: begin tx_gap_max = 8; rx_stall_max = 30; end
                endcase
            end
            if (payload_count % 25 == 0) wait_drained();
            kind = $urandom_range(19, 0);
            if (kind < 12) begin
                // well-formed message
                repeat ($urandom_range(8, 1)) put_random_field();
            end else if (kind < 15) begin
                // well-formed but cut short
                repeat ($urandom_range(6, 1)) put_random_field();
                keep = $urandom_range(msg_bytes.size(), 1);
                while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
            end else if (kind < 17) begin
                // bad wire type between good fields
                repeat ($urandom_range(3, 0)) put_random_field();
                put_tag(pick_field(), pick_bad_wire());
                repeat ($urandom_range(3, 0)) put_random_field();
            end else begin
                // noise
                repeat ($urandom_range(12, 1)) msg_bytes.push_back(8'($urandom));
            end
            send_msg();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n           <= 1'b0;
        byte_if.valid     <= 1'b0;
        byte_if.data_byte <= 8'h00;
        byte_if.last_byte <= 1'b0;
        clear_decoder();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_gap_max   = 2;
        rx_stall_max = 3;
        test_basic_fixes();
        test_repeated_fields();
        test_skipped_wire_types();
        wait_drained();
        tx_gap_max   = 0;
        rx_stall_max = 0;
        test_bad_wire_types();
        test_payload_endings();
        tx_gap_max   = 5;
        rx_stall_max = 20;
        test_long_varints();
        wait_drained();
        test_random_traffic();

        // drain, then let the pipeline settle
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (expected_fixes.size() != 0)
            report_mismatch("fixes never produced", 32'(expected_fixes.size()), 32'd0);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/ppp_pkg.sv
src/ppp_byte_if.sv
src/ppp_res_if.sv
src/ppp_front.sv
src/ppp_back.sv
src/protobuf_position_parser.sv
dv/tb_protobuf_position_parser.sv
